### hw/rtl/owbl_pkg.sv
// Shared types and constants for the one-wire backlight level encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package owbl_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned DUR_W   = 12;
    localparam int unsigned DATA_W  = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd32;
    localparam logic [LEVEL_W-1:0] ADDR_RESET = 8'h72;

    localparam logic [DUR_W-1:0] T_HOLD      = 12'd0;
    localparam logic [DUR_W-1:0] T_SHORT     = 12'd10;
    localparam logic [DUR_W-1:0] T_LONG      = 12'd180;
    localparam logic [DUR_W-1:0] T_SEL_HIGH1 = 12'd120;
    localparam logic [DUR_W-1:0] T_SEL_LOW   = 12'd280;
    localparam logic [DUR_W-1:0] T_SEL_HIGH2 = 12'd650;
    localparam logic [DUR_W-1:0] T_OFF       = 12'd3000;

    // Command kinds handed from the front to the back.
    localparam logic [1:0] K_OFF  = 2'd0;
    localparam logic [1:0] K_ZERO = 2'd1;
    localparam logic [1:0] K_SEND = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              msel;   // emit mode-select sequence first
        logic [7:0]        addr;
        logic [DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

### hw/rtl/owbl_front.sv
// Front end: accepts requests, clamps the level and tracks the mode-selected flag.
// Depends on owbl_pkg.
`default_nettype none
module owbl_front
    import owbl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_power_on,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire logic [7:0]         i_addr,
    input  wire t_q_stat            i_q_stat,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    logic               r_mode_sel;
    logic               n_mode_sel;
    logic [LEVEL_W-1:0] sat;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready;
    assign sat     = (i_level > LEVEL_MAX) ? LEVEL_MAX : i_level;

    always_comb begin
        o_cmd.msel = !r_mode_sel;
        o_cmd.addr = i_addr;
        // level-1 in five bits; a clamped 32 wraps to 31
        o_cmd.data = sat[DATA_W-1:0] - DATA_W'(1);
        n_mode_sel = r_mode_sel;
        if (!i_power_on) begin
            o_cmd.kind = K_OFF;
        end else if (i_level == '0) begin
            o_cmd.kind = K_ZERO;
            n_mode_sel = 1'b0;
        end else begin
            o_cmd.kind = K_SEND;
            n_mode_sel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_sel <= 1'b1;
        end else if (o_push) begin
            r_mode_sel <= n_mode_sel;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/owbl_queue.sv
// Two-entry command queue between front and back.
// Depends on owbl_pkg.
`default_nettype none
module owbl_queue
    import owbl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/owbl_back.sv
// Back end: sequences pin segments for one command at a time into an output register.
// Depends on owbl_pkg.
`default_nettype none
module owbl_back
    import owbl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_head,
    input  wire t_q_stat          i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_pin,
    output logic [DUR_W-1:0]      o_dur,
    output logic                  o_last
);

    localparam logic [1:0] ST_SEL  = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_ONE  = 2'd3;

    localparam logic [4:0] SEL_END   = 5'd2;
    localparam logic [4:0] FRAME_END = 5'd18;  // held high
    localparam logic [4:0] STOP_POS  = 5'd17;  // low end-of-stream

    logic             r_busy;
    t_cmd             r_cmd;
    logic [1:0]       r_st;
    logic [4:0]       r_cnt;
    logic             r_valid;
    logic             r_pin;
    logic [DUR_W-1:0] r_dur;
    logic             r_last;

    t_cmd             cur;
    logic [1:0]       cur_st;
    logic [4:0]       cur_cnt;
    logic             have;
    logic             adv;
    logic [7:0]       byte_v;
    logic [4:0]       jm;
    logic             bit_v;
    logic             seg_pin;
    logic [DUR_W-1:0] seg_dur;
    logic             seg_last;
    logic             seg_end;
    logic [1:0]       n_st;
    logic [4:0]       n_cnt;

    assign have    = r_busy || !i_q_stat.empty;
    assign adv     = have && (!r_valid || i_ready);
    assign o_pop   = adv && !r_busy;
    assign cur     = r_busy ? r_cmd : i_head;
    assign cur_cnt = r_busy ? r_cnt : 5'd0;

    always_comb begin
        if (r_busy) begin
            cur_st = r_st;
        end else if (i_head.kind != K_SEND) begin
            cur_st = ST_ONE;
        end else if (i_head.msel) begin
            cur_st = ST_SEL;
        end else begin
            cur_st = ST_ADDR;
        end
    end

    assign byte_v = (cur_st == ST_ADDR) ? cur.addr : {{(8-DATA_W){1'b0}}, cur.data};
    assign jm     = cur_cnt - 5'd1;
    assign bit_v  = byte_v[3'd7 - jm[3:1]];

    always_comb begin
        seg_pin  = 1'b0;
        seg_dur  = T_HOLD;
        seg_last = 1'b0;
        seg_end  = 1'b0;
        n_st     = cur_st;
        n_cnt    = cur_cnt + 5'd1;
        unique case (cur_st)
            ST_ONE: begin
                seg_pin  = 1'b0;
                seg_dur  = (cur.kind == K_ZERO) ? T_OFF : T_HOLD;
                seg_last = 1'b1;
                seg_end  = 1'b1;
            end
            ST_SEL: begin
                case (cur_cnt)
                    5'd0:    begin seg_pin = 1'b1; seg_dur = T_SEL_HIGH1; end
                    5'd1:    begin seg_pin = 1'b0; seg_dur = T_SEL_LOW;   end
                    default: begin seg_pin = 1'b1; seg_dur = T_SEL_HIGH2; end
                endcase
                if (cur_cnt == SEL_END) begin
                    n_st  = ST_ADDR;
                    n_cnt = 5'd0;
                end
            end
            default: begin
                if (cur_cnt == 5'd0) begin
                    seg_pin = 1'b1;
                    seg_dur = T_SHORT;
                end else if (cur_cnt == STOP_POS) begin
                    seg_pin = 1'b0;
                    seg_dur = T_SHORT;
                end else if (cur_cnt == FRAME_END) begin
                    seg_pin = 1'b1;
                    seg_dur = T_HOLD;
                end else begin
                    // low half then high half; a one has the short low
                    seg_pin = jm[0];
                    seg_dur = (bit_v ^ jm[0]) ? T_SHORT : T_LONG;
                end
                if (cur_cnt == FRAME_END) begin
                    n_st  = ST_DATA;
                    n_cnt = 5'd0;
                    if (cur_st == ST_DATA) begin
                        seg_last = 1'b1;
                        seg_end  = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_st    <= ST_ONE;
            r_cnt   <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                r_busy  <= !seg_end;
                r_st    <= n_st;
                r_cnt   <= n_cnt;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (adv) begin
            r_pin  <= seg_pin;
            r_dur  <= seg_dur;
            r_last <= seg_last;
        end
    end

    assign o_valid = r_valid;
    assign o_pin   = r_pin;
    assign o_dur   = r_dur;
    assign o_last  = r_last;

endmodule
`default_nettype wire

### hw/rtl/one_wire_backlight_level_encoder.sv
// Top level of the one-wire backlight level encoder: front, command queue, back.
// Depends on owbl_pkg, owbl_front, owbl_queue and owbl_back.
//
// Usage:
//   Slave stream (i_s_*): one beat is one backlight request. tdata[0] is power_on,
//   tdata[8:1] is the requested level; upper bits are ignored.
//   Master stream (o_m_*): one beat per pin segment. tdata[0] is the pin level,
//   tdata[12:1] the hold time in microseconds (0 = hold until the next segment);
//   tlast marks the final segment of a request.
//   Config channel (i_cfg_*): writes the device address byte; always ready.
//   Write it only while no request is in flight.
// Timing:
//   The first segment of a request passes through the command queue and the back
//   end's output register. The back end emits one segment per cycle while i_m_tready
//   is high, so a request spans 1 segment (panel off or level zero), 38 (address and
//   data frames) or 41 (mode select first); this segment sequencer sets the rate.
//   A two-entry command queue lets new requests be taken while segments drain.
// Reset:
//   Synchronous, active low. Clears the queue and the sequencer, sets the address
//   to 0x72 and assumes one-wire mode already selected.
// Stall:
//   While i_m_tready is low the current segment holds in the output register;
//   requests keep landing until the queue is full, then o_s_tready drops.
`default_nettype none
module one_wire_backlight_level_encoder
    import owbl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [0] power_on, [8:1] level, [15:9] zero
    // segment stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [0] pin_level, [12:1] duration_us, [15:13] zero
    output logic             o_m_tlast,
    // device address write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic             r_addr;
    logic [7:0]       r_dev_addr;
    logic             push;
    logic             pop;
    t_cmd             push_cmd;
    t_cmd             head;
    t_q_stat          q_stat;
    logic             seg_pin;
    logic [DUR_W-1:0] seg_dur;

    // Address register: always ready, written on each config beat.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
            r_addr     <= 1'b0;
        end else if (i_cfg_valid) begin
            r_dev_addr <= i_cfg_data;
            r_addr     <= 1'b1;
        end
    end

    // Classify the request and track mode select.
    owbl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_power_on (i_s_tdata[0]),
        .i_level    (i_s_tdata[8:1]),
        .i_addr     (r_dev_addr),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    owbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Expand each command into timed segments.
    owbl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_pin    (seg_pin),
        .o_dur    (seg_dur),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, seg_dur, seg_pin};

    // Final segments are held or the 3000 us off pulse.
    a_last_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (seg_dur == T_HOLD || seg_dur == T_OFF))
        else $error("final segment with a timed duration");

    // The held high only closes an address or data frame, and only the data one is last.
    // It either follows the end-of-stream low or is still waiting on a stalled receiver.
    a_held_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && seg_pin && seg_dur == T_HOLD && !o_m_tlast)
        |-> ($past(seg_dur) == T_SHORT
             || ($past(o_m_tvalid && !i_m_tready) && $past(seg_dur) == T_HOLD)))
        else $error("held high not preceded by end-of-stream");

    // Never pop an empty queue.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty command queue");

    // Address register follows each config beat.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_addr && r_dev_addr == $past(i_cfg_data)))
        else $error("device address write lost");

endmodule
`default_nettype wire

### test/owbl_segment_check.sv
`timescale 1ns / 1ps
// Segment scoreboard for the one-wire backlight level encoder: watches the request,
// segment and address-write channels, predicts every pin segment and compares.
// Depends on owbl_pkg for the field widths only.
module owbl_segment_check
    import owbl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,   // [0] power_on, [8:1] level, [15:9] zero
    input  logic        i_seg_valid,
    input  logic        i_seg_ready,
    input  logic [15:0] i_seg_data,   // [0] pin_level, [12:1] duration_us, [15:13] zero
    input  logic        i_seg_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [DUR_W-1:0] HOLD_TIME = 12'd0;
    localparam logic [DUR_W-1:0] PULSE_SHORT = 12'd10;
    localparam logic [DUR_W-1:0] PULSE_LONG = 12'd180;
    localparam logic [DUR_W-1:0] SEL_HIGH_A = 12'd120;
    localparam logic [DUR_W-1:0] SEL_LOW = 12'd280;
    localparam logic [DUR_W-1:0] SEL_HIGH_B = 12'd650;
    localparam logic [DUR_W-1:0] OFF_TIME = 12'd3000;
    localparam logic [7:0] TOP_LEVEL = 8'd32;
    localparam logic [7:0] ADDR_AT_RESET = 8'h72;

    typedef struct packed {
        logic             pin;
        logic [DUR_W-1:0] dur;
        logic             last;
    } pin_seg_t;

    pin_seg_t   seg_q[$];
    logic [7:0] dev_addr = ADDR_AT_RESET;
    logic       mode_sel = 1'b1;
    int         err_cnt = 0;

    function automatic void add_seg(logic pin, logic [DUR_W-1:0] dur, logic last);
        seg_q.push_back(pin_seg_t'{pin, dur, last});
    endfunction

    // One byte frame: start, eight pulse-width bits MSB first, end of stream, held high.
    function automatic void add_frame(logic [7:0] val, logic last);
        add_seg(1'b1, PULSE_SHORT, 1'b0);
        for (int b = 7; b >= 0; b--) begin
            if (val[b]) begin
                add_seg(1'b0, PULSE_SHORT, 1'b0);
                add_seg(1'b1, PULSE_LONG, 1'b0);
            end else begin
                add_seg(1'b0, PULSE_LONG, 1'b0);
                add_seg(1'b1, PULSE_SHORT, 1'b0);
            end
        end
        add_seg(1'b0, PULSE_SHORT, 1'b0);
        add_seg(1'b1, HOLD_TIME, last);
    endfunction

    function automatic void predict_request(logic power, logic [7:0] level);
        logic [7:0] lvl;
        logic [7:0] code;
        lvl = (level > TOP_LEVEL) ? TOP_LEVEL : level;
        code = lvl - 8'd1;
        if (!power) begin
            add_seg(1'b0, HOLD_TIME, 1'b1);
        end else if (lvl == 8'd0) begin
            add_seg(1'b0, OFF_TIME, 1'b1);
            mode_sel = 1'b0;
        end else begin
            if (!mode_sel) begin
                add_seg(1'b1, SEL_HIGH_A, 1'b0);
                add_seg(1'b0, SEL_LOW, 1'b0);
                add_seg(1'b1, SEL_HIGH_B, 1'b0);
                mode_sel = 1'b1;
            end
            add_frame(dev_addr, 1'b0);
            add_frame({3'b000, code[4:0]}, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        pin_seg_t want;
        if (!i_rst_n) begin
            seg_q.delete();
            dev_addr = ADDR_AT_RESET;
            mode_sel = 1'b1;
        end else begin
            if (i_seg_valid && i_seg_ready) begin
                if (seg_q.size() == 0) begin
                    $error("segment with nothing expected: pin_level %0d duration_us %0d",
                           i_seg_data[0], i_seg_data[12:1]);
                    err_cnt++;
                end else begin
                    want = seg_q.pop_front();
                    if (i_seg_data[0] !== want.pin) begin
                        $error("pin_level: expected %0d, got %0d", want.pin, i_seg_data[0]);
                        err_cnt++;
                    end
                    if (i_seg_data[12:1] !== want.dur) begin
                        $error("duration_us: expected %0d, got %0d",
                               want.dur, i_seg_data[12:1]);
                        err_cnt++;
                    end
                    if (i_seg_last !== want.last) begin
                        $error("last_segment: expected %0d, got %0d", want.last, i_seg_last);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                dev_addr = i_cfg_data;
            if (i_req_valid && i_req_ready)
                predict_request(i_req_data[0], i_req_data[8:1]);
        end
        o_errors <= err_cnt;
        o_pending <= seg_q.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the one-wire backlight level encoder: clock, reset,
// request and segment traffic, address writes and the verdict.
// Depends on owbl_pkg, the block's RTL and owbl_segment_check.
module tb;
    import owbl_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // [0] power_on, [8:1] level, [15:9] zero

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] pin_level, [12:1] duration_us, [15:13] zero
    logic        m_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;

    int          errors;
    int          pending;
    int          sent = 0;          // request beats accepted
    int          rx_beats = 0;      // segment beats accepted
    bit          long_done = 1'b0;

    // 10 ns period: high half, then low half.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    one_wire_backlight_level_encoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    owbl_segment_check seg_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(s_tvalid),
        .i_req_ready(s_tready),
        .i_req_data (s_tdata),
        .i_seg_valid(m_tvalid),
        .i_seg_ready(m_tready),
        .i_seg_data (m_tdata),
        .i_seg_last (m_tlast),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Offer one request beat. Idle for a random gap first, except in the back-to-back
    // window where valid stays high from beat to beat. Return at the falling edge
    // after the beat is taken, with valid still high.
    task automatic send_req(input logic pwr, input logic [7:0] lvl);
        int gap;
        gap = ((sent % 100) >= 60 && (sent % 100) < 80) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, lvl, pwr};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        sent++;
        @(negedge clk);
    endtask

    // Write the device address only once the block is idle: drop valid, drain every
    // expected segment, let the pipeline settle, then post the write beat.
    task automatic set_address(input logic [7:0] addr);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= addr;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Segment sink: draw a random stall per beat, with a no-stall stretch now and then,
    // and one long hold-off that backs the block up into its request side.
    initial begin : sink
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (rx_beats >= 3000 && !long_done && s_tvalid) begin
                // hold off while requests keep coming
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                long_done = 1'b1;
            end
            gap = ((rx_beats % 2000) >= 1700) ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            rx_beats++;
            @(negedge clk);
        end
    end

    initial begin : stim
        logic       pwr;
        logic [7:0] lvl;
        int         pick;

        // hold reset, then release at a falling edge
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Panel off, with the level field at both extremes.
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'hFF);
        // Level zero clears mode select; the next lit level must re-select it.
        send_req(1'b1, 8'd0);
        send_req(1'b1, 8'd1);
        send_req(1'b1, 8'd32);
        // Levels above the top saturate.
        send_req(1'b1, 8'd33);
        send_req(1'b1, 8'd255);
        send_req(1'b1, 8'h80);
        // Panel off leaves mode select alone, both when set and when cleared.
        send_req(1'b0, 8'h55);
        send_req(1'b1, 8'd0);
        send_req(1'b0, 8'd20);
        send_req(1'b1, 8'd20);
        send_req(1'b1, 8'hAA);
        send_req(1'b1, 8'h55);
        send_req(1'b1, 8'd16);
        send_req(1'b1, 8'd31);

        // Address extremes.
        set_address(8'h00);
        send_req(1'b1, 8'd1);
        send_req(1'b1, 8'd32);
        set_address(8'hFF);
        send_req(1'b1, 8'd0);
        send_req(1'b1, 8'd17);

        // Random phases, each under a fresh address. Mostly lit levels in range,
        // plus level zero, saturating levels and panel-off requests.
        for (int p = 0; p < 6; p++) begin
            set_address(8'($urandom_range(0, 255)));
            repeat (68) begin
                pwr = ($urandom_range(0, 9) != 0);
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    lvl = 8'd0;
                else if (pick < 7)
                    lvl = 8'($urandom_range(1, 32));
                else if (pick < 9)
                    lvl = 8'($urandom_range(33, 255));
                else
                    lvl = 8'($urandom_range(0, 255));
                send_req(pwr, lvl);
            end
        end

        // drain, then watch a little longer for stray segments
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #8_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
